>>> src/swrl_pkg.sv
// Shared types and constants for the sliding-window byte-rate limiter.
// Used by the interfaces, the controller, the datapath, the top level and the checker.
`default_nettype none

package swrl_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int SAMPLE_DEPTH_DEF = 64;
  localparam int WINDOW_MS_DEF    = 1000;

  // Field widths.
  localparam int TIME_W    = 48;
  localparam int BYTES_W   = 32;
  localparam int LIMIT_W   = 40;
  localparam int POLL_W    = 16;
  localparam int WAIT_W    = 16;
  localparam int BUDGET_W  = 64;
  localparam int TOTAL_W   = 40;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 40;

  localparam logic [WAIT_W-1:0]  WAIT_CLAMP_MS   = WAIT_W'(1000);
  localparam logic [POLL_W-1:0]  IDLE_POLL_RESET = POLL_W'(100);
  localparam logic [TIME_W-1:0]  TIME_MAX        = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX       = '1;

  // Item commands.
  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_POLL   = CFG_IDX_W'(1);

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_HEAD,
    OP_DROP,
    OP_APPEND,
    OP_RD_NEWEST,
    OP_MERGE,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_ANCHOR,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  // Status flags the datapath reports back to the controller.
  typedef struct packed {
    logic cmd;
    logic bytes_zero;
    logic limit_zero;
    logic before_deadline;
    logic prune_ok;
    logic count_zero;
    logic count_one;
    logic fifo_full;
    logic expired;
    logic sum_below;
    logic scan_more;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/swrl_if.sv
// Channel interfaces of the rate limiter: request items, result items, register writes.
// Depends on swrl_pkg for field widths.
`default_nettype none

interface swrl_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [swrl_pkg::TIME_W-1:0] now_ms;
  logic [swrl_pkg::BYTES_W-1:0] byte_count;

  modport source (output valid, cmd, now_ms, byte_count, input ready);
  modport sink   (input valid, cmd, now_ms, byte_count, output ready);
endinterface

interface swrl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          throttled;
  logic [swrl_pkg::WAIT_W-1:0]   wait_ms;
  logic [swrl_pkg::BUDGET_W-1:0] budget;
  logic [swrl_pkg::TOTAL_W-1:0]  window_total;
  logic                          overflow;

  modport source (output valid, throttled, wait_ms, budget, window_total, overflow,
                  input ready);
  modport sink   (input valid, throttled, wait_ms, budget, window_total, overflow,
                  output ready);
endinterface

interface swrl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swrl_pkg::CFG_IDX_W-1:0] index;
  logic [swrl_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/sliding_window_rate_limiter.sv
// Sliding-window byte-rate limiter, top level. Items are handled one at a time.
// From acceptance, an item loads its fields; if evaluated, a prune read of the head may follow,
// expired samples are then dropped one at a time (no extra read when the log empties), then the
// action step, then a merge for a full log, or a scan and anchor if the sum reaches the limit.
// Results wait for a free output register. The next item is accepted once the result appears.
// Reset (synchronous, active high) empties the log, clears sum and deadline, limit 0, poll 100.
`default_nettype none

// The block keeps a log of (time, bytes) samples in a circular memory of SAMPLE_DEPTH
// entries. A report item with a nonzero byte count first drops samples older than
// now_ms minus WINDOW_MS, one per cycle from the head, and then appends its sample.
// When the log is full, the bytes are merged into the newest sample with 32-bit
// saturation and the overflow flag of the result is set.
//
// A check item with a nonzero limit is throttled at once if now_ms lies before the
// stored deadline. Otherwise the log is pruned the same way, and if the window sum still
// reaches the limit, the controller walks the log from the oldest sample, subtracting
// bytes one sample per cycle until the rest falls below the limit. The time of the sample
// found there, plus WINDOW_MS + 1, becomes the new deadline if it lies later.
//
// The sample memory has a single read port with a registered output; all walks go
// through it, so each prune or scan step reads one sample. The result is held in an
// output register, so a new item is accepted while the last result waits to be taken.
// Writing speed_limit clears the deadline. Register writes are always accepted.

module sliding_window_rate_limiter #(
  parameter int SAMPLE_DEPTH = swrl_pkg::SAMPLE_DEPTH_DEF,
  parameter int WINDOW_MS    = swrl_pkg::WINDOW_MS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  swrl_req_if.sink   req,
  swrl_rsp_if.source rsp,
  swrl_cfg_if.sink   cfg
);

  swrl_pkg::dp_cmd_t    ctrl;
  swrl_pkg::dp_status_t stat;
  logic                 in_ready;

  assign req.ready = in_ready;

  swrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  swrl_datapath #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .WINDOW_MS    (WINDOW_MS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .req_cmd        (req.cmd),
    .req_now_ms     (req.now_ms),
    .req_byte_count (req.byte_count),
    .cfg            (cfg),
    .rsp            (rsp)
  );

endmodule

`default_nettype wire

>>> src/swrl_ctrl.sv
// Controller state machine of the rate limiter: sequences prune, append, merge and scan.
// Depends on swrl_pkg for the command and status structs.
`default_nettype none

module swrl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire swrl_pkg::dp_status_t stat,
  output swrl_pkg::dp_cmd_t         ctrl
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_START  = 8'b0000_0010,
    S_PRUNE  = 8'b0000_0100,
    S_ACT    = 8'b0000_1000,
    S_MERGE  = 8'b0001_0000,
    S_SCAN   = 8'b0010_0000,
    S_ANCHOR = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctrl.op    = swrl_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.op    = swrl_pkg::OP_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        // Zero-byte reports, unlimited checks and checks still inside the deadline
        // change nothing.
        if ((stat.cmd == swrl_pkg::CMD_REPORT) ? stat.bytes_zero
                                               : (stat.limit_zero || stat.before_deadline)) begin
          state_next = S_FINISH;
        end else if (stat.prune_ok && !stat.count_zero) begin
          ctrl.op    = swrl_pkg::OP_RD_HEAD;
          state_next = S_PRUNE;
        end else begin
          state_next = S_ACT;
        end
      end
      S_PRUNE: begin
        if (stat.expired) begin
          ctrl.op = swrl_pkg::OP_DROP;
          if (stat.count_one) begin
            state_next = S_ACT;
          end
        end else begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        if (stat.cmd == swrl_pkg::CMD_REPORT) begin
          if (!stat.fifo_full) begin
            ctrl.op    = swrl_pkg::OP_APPEND;
            state_next = S_FINISH;
          end else begin
            ctrl.op    = swrl_pkg::OP_RD_NEWEST;
            state_next = S_MERGE;
          end
        end else if (stat.sum_below || stat.count_zero) begin
          state_next = S_FINISH;
        end else begin
          ctrl.op    = swrl_pkg::OP_SCAN_INIT;
          state_next = S_SCAN;
        end
      end
      S_MERGE: begin
        ctrl.op    = swrl_pkg::OP_MERGE;
        state_next = S_FINISH;
      end
      S_SCAN: begin
        ctrl.op = swrl_pkg::OP_SCAN_STEP;
        if (!stat.scan_more) begin
          state_next = S_ANCHOR;
        end
      end
      S_ANCHOR: begin
        ctrl.op    = swrl_pkg::OP_ANCHOR;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctrl.op    = swrl_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> src/swrl_datapath.sv
// Datapath of the rate limiter: sample memory, FIFO pointers, window sum, deadline,
// configuration registers and the result register. Depends on swrl_pkg and swrl_if.
`default_nettype none

module swrl_datapath #(
  parameter int SAMPLE_DEPTH = swrl_pkg::SAMPLE_DEPTH_DEF,
  parameter int WINDOW_MS    = swrl_pkg::WINDOW_MS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire swrl_pkg::dp_cmd_t             ctrl,
  output swrl_pkg::dp_status_t               stat,
  input  wire logic                          req_cmd,
  input  wire logic [swrl_pkg::TIME_W-1:0]   req_now_ms,
  input  wire logic [swrl_pkg::BYTES_W-1:0]  req_byte_count,
  swrl_cfg_if.sink                           cfg,
  swrl_rsp_if.source                         rsp
);

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int CW = $clog2(SAMPLE_DEPTH + 1);
  localparam int SW = swrl_pkg::BYTES_W + CW;
  localparam int TW = swrl_pkg::TIME_W;
  localparam int BW = swrl_pkg::BYTES_W;

  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(SAMPLE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(SAMPLE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(SAMPLE_DEPTH - 1);
  localparam logic [TW-1:0] WIN_T     = TW'(WINDOW_MS);
  localparam logic [TW:0]   UNTIL_ADD = (TW + 1)'(WINDOW_MS + 1);

  // Sample memory.
  logic [TW-1:0] sample_time  [SAMPLE_DEPTH];
  logic [BW-1:0] sample_bytes [SAMPLE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [BW-1:0] mem_wb;
  logic [AW-1:0] rd_addr;
  logic [TW-1:0] rd_time;
  logic [BW-1:0] rd_bytes;

  // Item and state registers.
  logic                           cur_cmd;
  logic [TW-1:0]                  cur_now;
  logic [BW-1:0]                  cur_bytes;
  logic [swrl_pkg::LIMIT_W-1:0]   speed_limit;
  logic [swrl_pkg::POLL_W-1:0]    idle_poll_ms;
  logic [AW-1:0]                  fifo_head;
  logic [CW-1:0]                  fifo_count;
  logic [SW-1:0]                  window_sum;
  logic [TW-1:0]                  throttle_deadline;
  logic                           ovf;
  logic [SW-1:0]                  rest;
  logic [AW-1:0]                  ptr;
  logic [CW-1:0]                  scan_k;

  // Result register.
  logic                           out_valid;
  logic                           out_thr;
  logic [swrl_pkg::WAIT_W-1:0]    out_wait;
  logic [swrl_pkg::BUDGET_W-1:0]  out_budget;
  logic [swrl_pkg::TOTAL_W-1:0]   out_total;
  logic                           out_ovf;

  // Derived values.
  logic [AW-1:0] head_inc;
  logic [AW-1:0] ptr_inc;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] newest;
  logic [TW-1:0] cutoff;
  logic [63:0]   sum64;
  logic [63:0]   lim64;
  logic [SW-1:0] rest_sub;
  logic [CW-1:0] k_inc;
  logic [BW:0]   sat_sum;
  logic [BW-1:0] merged;
  logic [BW-1:0] merge_add;
  logic [TW:0]   until_x;
  logic [TW-1:0] new_deadline;
  logic [TW-1:0] remain;
  logic          thr;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
    slot_inc = (a == LAST_SLOT) ? '0 : a + AW'(1);
  endfunction

  always_comb begin
    head_inc     = slot_inc(fifo_head);
    ptr_inc      = slot_inc(ptr);
    tail_sum     = {1'b0, fifo_head} + (AW + 1)'(fifo_count);
    tail         = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : tail_sum[AW-1:0];
    newest       = (tail == '0) ? LAST_SLOT : tail - AW'(1);
    cutoff       = cur_now - WIN_T;
    sum64        = 64'(window_sum);
    lim64        = 64'(speed_limit);
    rest_sub     = rest - SW'(rd_bytes);
    k_inc        = scan_k + CW'(1);
    sat_sum      = {1'b0, rd_bytes} + {1'b0, cur_bytes};
    merged       = sat_sum[BW] ? '1 : sat_sum[BW-1:0];
    merge_add    = merged - rd_bytes;
    until_x      = {1'b0, rd_time} + UNTIL_ADD;
    new_deadline = until_x[TW] ? swrl_pkg::TIME_MAX : until_x[TW-1:0];
    remain       = throttle_deadline - cur_now;
    thr          = (speed_limit != '0) && (cur_now < throttle_deadline);
  end

  always_comb begin
    stat.cmd             = cur_cmd;
    stat.bytes_zero      = (cur_bytes == '0);
    stat.limit_zero      = (speed_limit == '0);
    stat.before_deadline = (cur_now < throttle_deadline);
    stat.prune_ok        = (cur_now >= WIN_T);
    stat.count_zero      = (fifo_count == '0);
    stat.count_one       = (fifo_count == CW'(1));
    stat.fifo_full       = (fifo_count == DEPTH_C);
    stat.expired         = (rd_time < cutoff);
    stat.sum_below       = (sum64 < lim64);
    stat.scan_more       = (k_inc < fifo_count) && (64'(rest_sub) >= lim64);
    stat.out_free        = !out_valid || rsp.ready;
  end

  // Read address and write port of the sample memory.
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = tail;
    mem_wb  = cur_bytes;
    rd_addr = fifo_head;
    case (ctrl.op)
      swrl_pkg::OP_DROP:      rd_addr = head_inc;
      swrl_pkg::OP_RD_NEWEST: rd_addr = newest;
      swrl_pkg::OP_SCAN_STEP: rd_addr = (k_inc < fifo_count) ? ptr_inc : ptr;
      swrl_pkg::OP_APPEND: begin
        mem_we = 1'b1;
      end
      swrl_pkg::OP_MERGE: begin
        mem_we = 1'b1;
        mem_wa = newest;
        mem_wb = merged;
      end
      default: rd_addr = fifo_head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_time[mem_wa]  <= cur_now;
      sample_bytes[mem_wa] <= mem_wb;
    end
    rd_time  <= sample_time[rd_addr];
    rd_bytes <= sample_bytes[rd_addr];
  end

  // Item registers and scan working registers.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      swrl_pkg::OP_LOAD: begin
        cur_cmd   <= req_cmd;
        cur_now   <= req_now_ms;
        cur_bytes <= req_byte_count;
      end
      swrl_pkg::OP_SCAN_INIT: begin
        rest   <= window_sum;
        ptr    <= fifo_head;
        scan_k <= '0;
      end
      swrl_pkg::OP_SCAN_STEP: begin
        rest   <= rest_sub;
        ptr    <= ptr_inc;
        scan_k <= k_inc;
      end
      default: begin
      end
    endcase
  end

  // FIFO state, deadline and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head         <= '0;
      fifo_count        <= '0;
      window_sum        <= '0;
      throttle_deadline <= '0;
      speed_limit       <= '0;
      idle_poll_ms      <= swrl_pkg::IDLE_POLL_RESET;
      ovf               <= 1'b0;
    end else begin
      case (ctrl.op)
        swrl_pkg::OP_LOAD: begin
          ovf <= 1'b0;
        end
        swrl_pkg::OP_DROP: begin
          window_sum <= window_sum - SW'(rd_bytes);
          fifo_head  <= head_inc;
          fifo_count <= fifo_count - CW'(1);
        end
        swrl_pkg::OP_APPEND: begin
          window_sum <= window_sum + SW'(cur_bytes);
          fifo_count <= fifo_count + CW'(1);
        end
        swrl_pkg::OP_MERGE: begin
          window_sum <= window_sum + SW'(merge_add);
          ovf        <= 1'b1;
        end
        swrl_pkg::OP_ANCHOR: begin
          if (new_deadline > throttle_deadline) begin
            throttle_deadline <= new_deadline;
          end
        end
        default: begin
        end
      endcase
      if (cfg.valid) begin
        unique case (cfg.index)
          swrl_pkg::REG_SPEED_LIMIT: begin
            speed_limit       <= cfg.data[swrl_pkg::LIMIT_W-1:0];
            throttle_deadline <= '0;
          end
          swrl_pkg::REG_IDLE_POLL: begin
            idle_poll_ms <= cfg.data[swrl_pkg::POLL_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign cfg.ready = 1'b1;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == swrl_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == swrl_pkg::OP_OUT) begin
      out_thr <= thr;
      if (!thr) begin
        out_wait <= idle_poll_ms;
      end else if (remain > TW'(swrl_pkg::WAIT_CLAMP_MS)) begin
        out_wait <= swrl_pkg::WAIT_CLAMP_MS;
      end else begin
        out_wait <= remain[swrl_pkg::WAIT_W-1:0];
      end
      if (speed_limit == '0) begin
        out_budget <= '1;
      end else if (sum64 < lim64) begin
        out_budget <= lim64 - sum64;
      end else begin
        out_budget <= '0;
      end
      out_total <= (sum64 > 64'(swrl_pkg::TOTAL_MAX)) ? swrl_pkg::TOTAL_MAX
                                                       : sum64[swrl_pkg::TOTAL_W-1:0];
      out_ovf   <= ovf;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.throttled    = out_thr;
  assign rsp.wait_ms      = out_wait;
  assign rsp.budget       = out_budget;
  assign rsp.window_total = out_total;
  assign rsp.overflow     = out_ovf;

endmodule

`default_nettype wire

>>> src/swrl_checker.sv
// Port-level checker for the rate limiter, bound to the top level.
// Depends on swrl_pkg for the wait clamp and field widths.
`default_nettype none

module swrl_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic                            rsp_throttled,
  input wire logic [swrl_pkg::WAIT_W-1:0]     rsp_wait_ms,
  input wire logic [swrl_pkg::BUDGET_W-1:0]   rsp_budget
);

  // Items are taken one at a time: after an accept the input side closes.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous item still in progress");

  // A pending result is not withdrawn.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before it was taken");

  // A throttled result carries a wait between one millisecond and the clamp.
  a_wait_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_throttled |->
      (rsp_wait_ms >= swrl_pkg::WAIT_W'(1)) && (rsp_wait_ms <= swrl_pkg::WAIT_CLAMP_MS))
    else $error("throttled wait outside the clamp range");

  // An unlimited budget never comes with throttling.
  a_unlimited: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_budget == '1) |-> !rsp_throttled)
    else $error("throttled while unlimited");

endmodule

bind sliding_window_rate_limiter swrl_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_throttled (rsp.throttled),
  .rsp_wait_ms   (rsp.wait_ms),
  .rsp_budget    (rsp.budget)
);

`default_nettype wire

>>> tb/tb_sliding_window_rate_limiter.sv
// Self-checking testbench for the sliding-window byte-rate limiter.
// Depends on swrl_pkg, the swrl channel interfaces and the sliding_window_rate_limiter top level.
// A built-in predictor tracks the sample log, window sum and deadline, and every result is checked.

module tb_sliding_window_rate_limiter;
  import swrl_pkg::*;

  localparam int DEPTH         = SAMPLE_DEPTH_DEF;
  localparam int WIN_MS        = WINDOW_MS_DEF;
  localparam int TW1           = TIME_W + 1;
  // Cycles allowed after the last result, above the worst item latency
  // (a full prune plus a full deadline scan).
  localparam int SETTLE_CYCLES = 2 * DEPTH + 80;
  // Hard stop, several times the slowest correct run.
  localparam int STOP_TIME     = 8_000_000;

  // Highest register index; it maps to no register and must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_IDX_LAST = '1;

  // One entry of the traffic that the driver plays out: either a request item
  // or a register write. A drain entry is held back until every result is in.
  typedef struct {
    logic                 is_write;
    logic                 drain;
    logic                 cmd;
    logic [TIME_W-1:0]    now_ms;
    logic [BYTES_W-1:0]   byte_count;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_data;
  } traffic_t;

  // The throttle verdict returned for one request item.
  typedef struct {
    logic                throttled;
    logic [WAIT_W-1:0]   wait_ms;
    logic [BUDGET_W-1:0] budget;
    logic [TOTAL_W-1:0]  window_total;
    logic                overflow;
  } verdict_t;

  logic clk;
  logic rst;

  swrl_req_if req_ch ();
  swrl_rsp_if rsp_ch ();
  swrl_cfg_if cfg_ch ();

  sliding_window_rate_limiter #(
    .SAMPLE_DEPTH(DEPTH),
    .WINDOW_MS   (WIN_MS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always #10 clk = ~clk;

  traffic_t traffic_q[$];
  verdict_t verdict_q[$];
  traffic_t active_item;
  traffic_t active_write;
  int       verdict_errors;
  int       burst_left;
  int       gap_left;
  int       stall_tick;
  logic [TIME_W-1:0] stim_now;

  // Predicted state of the limiter: the sample log as a circular buffer, the
  // exact byte sum of the log, the throttle deadline and both registers.
  logic [TIME_W-1:0]  log_time [DEPTH];
  logic [BYTES_W-1:0] log_bytes [DEPTH];
  int unsigned        log_head;
  int unsigned        log_count;
  logic [63:0]        win_sum;
  logic [TIME_W-1:0]  deadline;
  logic [LIMIT_W-1:0] limit_reg;
  logic [POLL_W-1:0]  poll_reg;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    verdict_errors++;
  endtask

  // Drops samples older than now minus the window. Early in time (now below
  // the window length) nothing can be old enough, so nothing is dropped.
  function automatic void drop_expired(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] cutoff;
    if (now < TIME_W'(WIN_MS)) return;
    cutoff = now - TIME_W'(WIN_MS);
    while (log_count > 0 && log_time[log_head] < cutoff) begin
      win_sum   -= 64'(log_bytes[log_head]);
      log_head   = (log_head + 1) % DEPTH;
      log_count -= 1;
    end
  endfunction

  // Logs received bytes and returns the overflow flag. With a full log the
  // bytes go into the newest sample, saturating at 32 bits; only the part that
  // fits is added to the window sum.
  function automatic logic log_received(logic [TIME_W-1:0] now, logic [BYTES_W-1:0] nbytes);
    int unsigned        s;
    logic [BYTES_W-1:0] room;
    logic [BYTES_W-1:0] added;
    drop_expired(now);
    if (log_count < DEPTH) begin
      s              = (log_head + log_count) % DEPTH;
      log_time[s]    = now;
      log_bytes[s]   = nbytes;
      log_count     += 1;
      win_sum       += 64'(nbytes);
      return 1'b0;
    end
    s            = (log_head + log_count - 1) % DEPTH;
    room         = '1 - log_bytes[s];
    added        = (nbytes < room) ? nbytes : room;
    log_bytes[s] = log_bytes[s] + added;
    log_time[s]  = now;
    win_sum     += 64'(added);
    return 1'b1;
  endfunction

  // Prunes, then, if the window still holds at least the limit, walks the log
  // from the oldest sample until the remainder drops below the limit. The
  // sample reached there (or the newest one if the walk ran off the end) sets
  // the new deadline, which saturates at the top of the time range and only
  // ever moves forward.
  function automatic void extend_deadline(logic [TIME_W-1:0] now);
    logic [63:0]       rest;
    int unsigned       k;
    logic [TIME_W-1:0] anchor;
    logic [TW1-1:0]    until_t;
    drop_expired(now);
    if (win_sum < 64'(limit_reg) || log_count == 0) return;
    rest = win_sum;
    k    = 0;
    while (k < log_count && rest >= 64'(limit_reg)) begin
      rest -= 64'(log_bytes[(log_head + k) % DEPTH]);
      k++;
    end
    if (k < log_count) anchor = log_time[(log_head + k) % DEPTH];
    else anchor = log_time[(log_head + log_count - 1) % DEPTH];
    until_t = {1'b0, anchor} + TW1'(WIN_MS + 1);
    if (until_t > {1'b0, TIME_MAX}) until_t = {1'b0, TIME_MAX};
    if (until_t[TIME_W-1:0] > deadline) deadline = until_t[TIME_W-1:0];
  endfunction

  // Works out the verdict of one accepted request item and updates the state.
  function automatic verdict_t predict_verdict(traffic_t it);
    verdict_t          v;
    logic [TIME_W-1:0] remain;
    v.overflow  = 1'b0;
    v.throttled = 1'b0;
    if (it.cmd == CMD_REPORT) begin
      // A report never evaluates; a zero byte count leaves the state alone.
      if (it.byte_count != '0) v.overflow = log_received(it.now_ms, it.byte_count);
      v.throttled = (limit_reg != '0) && (it.now_ms < deadline);
    end else if (limit_reg != '0) begin
      if (it.now_ms < deadline) begin
        v.throttled = 1'b1;
      end else begin
        extend_deadline(it.now_ms);
        v.throttled = it.now_ms < deadline;
      end
    end
    v.wait_ms = poll_reg;
    if (v.throttled) begin
      remain = deadline - it.now_ms;
      if (remain > TIME_W'(WAIT_CLAMP_MS)) v.wait_ms = WAIT_CLAMP_MS;
      else v.wait_ms = remain[WAIT_W-1:0];
    end
    if (limit_reg == '0) v.budget = '1;
    else if (win_sum >= 64'(limit_reg)) v.budget = '0;
    else v.budget = 64'(limit_reg) - win_sum;
    v.window_total = (win_sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : win_sum[TOTAL_W-1:0];
    return v;
  endfunction

  function automatic void push_item(logic cmd, logic [TIME_W-1:0] now,
                                    logic [BYTES_W-1:0] nbytes, logic drain);
    traffic_t t;
    t            = '{default: '0};
    t.cmd        = cmd;
    t.now_ms     = now;
    t.byte_count = nbytes;
    t.drain      = drain;
    traffic_q.insert(traffic_q.size(), t);
  endfunction

  function automatic void push_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    traffic_t t;
    t          = '{default: '0};
    t.is_write = 1'b1;
    t.reg_idx  = idx;
    t.reg_data = data;
    traffic_q.insert(traffic_q.size(), t);
  endfunction

  // Moves the stimulus clock forward, pinned at the top of the time range.
  function automatic void advance_time(logic [TIME_W-1:0] step);
    if (TIME_MAX - stim_now < step) stim_now = TIME_MAX;
    else stim_now = stim_now + step;
  endfunction

  // One random phase: new register settings, then a run of items. A flood
  // phase packs reports densely in time so the log fills up and merges happen.
  function automatic void add_phase(int n_items, logic flood);
    int                 step_mode;
    int                 size_mode;
    logic [LIMIT_W-1:0] lim;
    logic [BYTES_W-1:0] nbytes;
    logic [TIME_W-1:0]  step;
    logic [TIME_W-1:0]  back;
    logic               cmd;
    case ($urandom_range(0, 7))
      0: lim = '0;
      1: lim = LIMIT_W'(1);
      2: lim = LIMIT_W'($urandom_range(1, 5000));
      3: lim = LIMIT_W'($urandom_range(5000, 300000));
      4: lim = {8'($urandom), 32'($urandom)};
      5: lim = '1;
      default: lim = LIMIT_W'($urandom_range(100, 3000));
    endcase
    push_write(REG_SPEED_LIMIT, CFG_DAT_W'(lim));
    if ($urandom_range(0, 1) == 1) push_write(REG_IDLE_POLL, {8'($urandom), 32'($urandom)});
    if ($urandom_range(0, 4) == 0) begin
      push_write(CFG_IDX_W'($urandom_range(REG_IDLE_POLL + 1, REG_IDX_LAST)),
                 {8'($urandom), 32'($urandom)});
    end

    if (flood) begin
      stim_now = {16'($urandom), 32'($urandom)} >> 1;
    end else begin
      case ($urandom_range(0, 5))
        0: stim_now = {16'($urandom), 32'($urandom)};
        1: stim_now = TIME_MAX - TIME_W'($urandom_range(0, 3000));
        2: advance_time(TIME_W'($urandom_range(WIN_MS + 1, 5 * WIN_MS)));
        default: ;
      endcase
    end
    step_mode = flood ? 0 : $urandom_range(0, 2);
    size_mode = flood ? 2 * $urandom_range(0, 1) : $urandom_range(0, 2);

    for (int i = 0; i < n_items; i++) begin
      case (step_mode)
        0: step = TIME_W'($urandom_range(0, 3));
        1: step = TIME_W'($urandom_range(0, 60));
        default: step = TIME_W'($urandom_range(0, 400));
      endcase
      if ($urandom_range(0, 29) == 0) step = TIME_W'($urandom_range(0, 3 * WIN_MS));
      if ($urandom_range(0, 49) == 0) begin
        // Time occasionally steps back.
        back     = TIME_W'($urandom_range(0, 500));
        stim_now = (stim_now > back) ? stim_now - back : '0;
      end else begin
        advance_time(step);
      end
      if (flood) cmd = ($urandom_range(0, 99) < 85) ? CMD_REPORT : CMD_CHECK;
      else cmd = ($urandom_range(0, 1) == 1) ? CMD_CHECK : CMD_REPORT;
      if ($urandom_range(0, 11) == 0) begin
        nbytes = '0;
      end else begin
        case (size_mode)
          0: nbytes = BYTES_W'($urandom_range(1, 200));
          1: nbytes = BYTES_W'($urandom_range(1, 5000));
          default: nbytes = $urandom;
        endcase
      end
      push_item(cmd, stim_now, nbytes, i == 0 || $urandom_range(0, 39) == 0);
    end
  endfunction

  // Driver. Plays the traffic queue out in bursts with random gaps. Register
  // writes go out only when no result is owed, so the block is idle. On every
  // accepted item or write the predictor is advanced in acceptance order.
  always @(posedge clk) begin : traffic_driver
    logic req_fire;
    logic cfg_fire;
    logic next_req_valid;
    logic next_cfg_valid;
    if (rst) begin
      req_ch.valid <= 1'b0;
      cfg_ch.valid <= 1'b0;
      log_head      = 0;
      log_count     = 0;
      win_sum       = '0;
      deadline      = '0;
      limit_reg     = '0;
      poll_reg      = IDLE_POLL_RESET;
      burst_left    = 1;
      gap_left      = 0;
    end else begin
      req_fire = req_ch.valid && req_ch.ready;
      cfg_fire = cfg_ch.valid && cfg_ch.ready;
      if (req_fire) verdict_q.insert(verdict_q.size(), predict_verdict(active_item));
      if (cfg_fire) begin
        case (active_write.reg_idx)
          REG_SPEED_LIMIT: begin
            // A new limit also forgets any pending deadline.
            limit_reg = active_write.reg_data[LIMIT_W-1:0];
            deadline  = '0;
          end
          REG_IDLE_POLL: poll_reg = active_write.reg_data[POLL_W-1:0];
          default: ;
        endcase
      end

      // Anything offered and not yet taken is held as it is.
      if (!((req_ch.valid && !req_fire) || (cfg_ch.valid && !cfg_fire))) begin
        next_req_valid = 1'b0;
        next_cfg_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (traffic_q.size() != 0) begin
          if (traffic_q[0].is_write) begin
            if (verdict_q.size() == 0) begin
              active_write    = traffic_q[0];
              traffic_q.delete(0);
              cfg_ch.index   <= active_write.reg_idx;
              cfg_ch.data    <= active_write.reg_data;
              next_cfg_valid  = 1'b1;
            end
          end else if (!traffic_q[0].drain || verdict_q.size() == 0) begin
            active_item        = traffic_q[0];
            traffic_q.delete(0);
            req_ch.cmd        <= active_item.cmd;
            req_ch.now_ms     <= active_item.now_ms;
            req_ch.byte_count <= active_item.byte_count;
            next_req_valid     = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 24);
              gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
          end
        end
        req_ch.valid <= next_req_valid;
        cfg_ch.valid <= next_cfg_valid;
      end
    end
  end

  // Monitor. Checks each accepted result against the oldest owed verdict and
  // drives the result ready through four stall patterns in turn: always
  // ready, coin flips, one cycle in five, and long stalls.
  always @(posedge clk) begin : verdict_monitor
    verdict_t want;
    logic     ready_next;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_tick    = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = verdict_q[0];
          verdict_q.delete(0);
          if (rsp_ch.throttled !== want.throttled)
            report_mismatch($sformatf("throttled got %b want %b",
                                      rsp_ch.throttled, want.throttled));
          if (rsp_ch.wait_ms !== want.wait_ms)
            report_mismatch($sformatf("wait_ms got %0d want %0d",
                                      rsp_ch.wait_ms, want.wait_ms));
          if (rsp_ch.budget !== want.budget)
            report_mismatch($sformatf("budget got %h want %h", rsp_ch.budget, want.budget));
          if (rsp_ch.window_total !== want.window_total)
            report_mismatch($sformatf("window_total got %h want %h",
                                      rsp_ch.window_total, want.window_total));
          if (rsp_ch.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %b want %b",
                                      rsp_ch.overflow, want.overflow));
        end
      end
      stall_tick++;
      case ((stall_tick / 97) % 4)
        0: ready_next = 1'b1;
        1: ready_next = $urandom_range(0, 1) == 1;
        2: ready_next = (stall_tick % 5) == 0;
        default: ready_next = (stall_tick % 16) < 4;
      endcase
      rsp_ch.ready <= ready_next;
    end
  end

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = CMD_REPORT;
    req_ch.now_ms     = '0;
    req_ch.byte_count = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_SPEED_LIMIT;
    cfg_ch.data       = '0;
    rsp_ch.ready      = 1'b0;
    verdict_errors    = 0;

    // Directed part. Out of reset the limit is zero, so checks are never
    // throttled and the budget reads all ones; a zero-byte report is ignored.
    push_item(CMD_CHECK, TIME_W'(0), '0, 1'b0);
    push_item(CMD_REPORT, TIME_W'(0), '0, 1'b0);
    push_item(CMD_REPORT, TIME_W'(5), '1, 1'b0);
    push_item(CMD_REPORT, TIME_W'(10), BYTES_W'(1), 1'b0);

    // A limit far below the logged bytes throttles the next check. Times stay
    // below one window at first, so nothing is pruned yet.
    push_write(REG_SPEED_LIMIT, CFG_DAT_W'(1000));
    push_write(REG_IDLE_POLL, '1);
    push_item(CMD_CHECK, TIME_W'(500), '0, 1'b0);
    // A report only echoes the stored deadline.
    push_item(CMD_REPORT, TIME_W'(600), BYTES_W'(7), 1'b0);
    // At the deadline the early samples are pruned and the check passes.
    push_item(CMD_CHECK, TIME_W'(1011), '0, 1'b0);
    // Time going back before the deadline is throttled again.
    push_item(CMD_CHECK, TIME_W'(900), '0, 1'b0);
    // A single sample over the limit: the scan runs off the end and the
    // newest sample anchors the deadline; the wait is clamped at the top.
    push_item(CMD_REPORT, TIME_W'(2500), BYTES_W'(2000), 1'b0);
    push_item(CMD_CHECK, TIME_W'(2500), '0, 1'b0);
    // One millisecond before the deadline gives the smallest wait.
    push_item(CMD_CHECK, TIME_W'(3500), '0, 1'b0);

    // Largest limit and a zero idle poll.
    push_write(REG_SPEED_LIMIT, '1);
    push_write(REG_IDLE_POLL, '0);
    push_item(CMD_CHECK, TIME_W'(3501), '0, 1'b0);

    // Unmapped register, then a one-byte limit near the top of the time range
    // so that the deadline saturates.
    push_write(REG_IDX_LAST, {8'($urandom), 32'($urandom)});
    push_write(REG_SPEED_LIMIT, CFG_DAT_W'(1));
    push_item(CMD_REPORT, TIME_MAX - TIME_W'(3), BYTES_W'(5), 1'b0);
    push_item(CMD_CHECK, TIME_MAX - TIME_W'(3), '0, 1'b0);
    push_item(CMD_CHECK, TIME_MAX, '0, 1'b0);
    push_item(CMD_REPORT, TIME_MAX, BYTES_W'(1), 1'b0);
    stim_now = TIME_MAX;

    // Random part: one flood phase to fill the log, then mixed phases.
    add_phase(80, 1'b1);
    for (int p = 0; p < 7; p++) add_phase(52, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Sample at the falling edge so every update of the rising edge is seen.
    do @(negedge clk);
    while (traffic_q.size() != 0 || req_ch.valid || cfg_ch.valid || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (verdict_errors == 0) begin
      $display("sliding_window_rate_limiter test passed");
    end else begin
      $display("sliding_window_rate_limiter test failed");
    end
    $finish;
  end

  initial begin
    #(STOP_TIME);
    $display("sliding_window_rate_limiter test failed");
    $finish;
  end

endmodule

>>> sim.f
src/swrl_pkg.sv
src/swrl_if.sv
src/swrl_ctrl.sv
src/swrl_datapath.sv
src/sliding_window_rate_limiter.sv
src/swrl_checker.sv
tb/tb_sliding_window_rate_limiter.sv
